@@ rtl/core/sorted_array_table_defines.svh @@
// Assertion macros shared by the sorted array table RTL.
`ifndef SORTED_ARRAY_TABLE_DEFINES_SVH
`define SORTED_ARRAY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define SAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted_array_table: assertion failed");

// Next-cycle implication, disabled while reset is high
`define SAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted_array_table: assertion failed");

`endif

@@ rtl/core/sat_pkg.sv @@
// Package for the sorted array table: beat types, command and status codes.
package sat_pkg;

   localparam int CAPACITY_DEFAULT = 32;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 6;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

endpackage

@@ rtl/core/sorted_array_table.sv @@
// Sorted array table: top level with command sequencer and entry memory.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------
//   req     | in        | req_valid / req_ready | cmd, value
//   rsp     | out       | rsp_valid / rsp_ready | status, position, count
//
// Clear, append, empty-table insert, unused codes and early fails go straight to S_DONE.
// Search walks one entry a cycle from index zero; insert walks down from the top
// slot moving larger entries up; delete then moves each later entry down one place.
// Synchronous reset empties the table (count zero); entry contents persist.
// req_ready is high only when the sequencer is idle; a result waiting in the
// output register stalls the sequencer only when the next result is due.
module sorted_array_table #(
   parameter int CAPACITY = sat_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sat_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sat_pkg::rsp_type rsp
);
   import sat_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_PUT,
      S_SRCH,
      S_DEL,
      S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          used_ff, used_in;
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [STATUS_W-1:0]       st_ff, st_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   // Entry memory: one write and one registered read per cycle
   logic signed [VALUE_W-1:0] mem [CAPACITY];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   logic                      full;
   logic [CNT_W-1:0]          used_m1;
   logic [CNT_W-1:0]          idx_p1;
   logic [CNT_W-1:0]          idx_p2;
   logic [31:0]               pos_wide;
   logic [31:0]               cnt_wide;

   assign full     = (used_ff >= CAP_CNT);
   assign used_m1  = used_ff - CNT_W'(1);
   assign idx_p1   = {1'b0, idx_ff} + CNT_W'(1);
   assign idx_p2   = {1'b0, idx_ff} + CNT_W'(2);
   assign pos_wide = 32'(pos_ff);
   assign cnt_wide = 32'(used_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Sequencer next-state and memory control
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      st_in        = st_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = val_ff;

      // result taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req.cmd;
               val_in   = req.value;
               st_in    = ST_OK;
               pos_in   = '0;
               state_in = S_DONE;
               case (req.cmd) inside
                  CMD_CLEAR: begin
                     used_in = '0;
                  end
                  CMD_APPEND: begin
                     if (full) begin
                        st_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = used_ff[IDX_W-1:0];
                        wr_data = req.value;
                        used_in = used_ff + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (full) begin
                        st_in = ST_FULL;
                     end else if (used_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = req.value;
                        used_in = used_ff + CNT_W'(1);
                     end else begin
                        // walk down from the free slot at the top
                        idx_in   = used_ff[IDX_W-1:0];
                        rd_addr  = used_m1[IDX_W-1:0];
                        state_in = S_INS;
                     end
                  end
                  CMD_SEARCH, CMD_DELETE: begin
                     if (used_ff == '0) begin
                        st_in = ST_ABSENT;
                     end else begin
                        idx_in   = '0;
                        rd_addr  = '0;
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // move a larger entry up one place, or stop at the slot
         S_INS: begin
            if (val_ff < rd_data_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data_ff;
               idx_in  = idx_ff - IDX_W'(1);
               if (idx_ff == IDX_W'(1)) begin
                  state_in = S_PUT;
               end else begin
                  rd_addr = idx_ff - IDX_W'(2);
               end
            end else begin
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = val_ff;
            used_in  = used_ff + CNT_W'(1);
            state_in = S_DONE;
         end

         // skip smaller entries, then test for a match
         S_SRCH: begin
            if (val_ff > rd_data_ff) begin
               if (idx_p1 == used_ff) begin
                  st_in    = ST_ABSENT;
                  state_in = S_DONE;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end else if (val_ff < rd_data_ff) begin
               st_in    = ST_ABSENT;
               state_in = S_DONE;
            end else begin
               pos_in = idx_ff;
               if (cmd_ff == CMD_DELETE) begin
                  if (idx_p1 < used_ff) begin
                     rd_addr  = idx_ff + IDX_W'(1);
                     state_in = S_DEL;
                  end else begin
                     used_in  = used_m1;
                     state_in = S_DONE;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // close the gap: each later entry moves down one place
         S_DEL: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = idx_ff + IDX_W'(1);
            if (idx_p2 < used_ff) begin
               rd_addr = idx_ff + IDX_W'(2);
            end else begin
               used_in  = used_m1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = st_ff;
               rsp_in.position = pos_wide[POS_W-1:0];
               rsp_in.count    = cnt_wide[COUNT_W-1:0];
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      st_ff  <= st_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

`include "sorted_array_table_defines.svh"

   `SAT_ASSERT_IMPL(a_used_bound, clock, reset, 1'b1, used_ff <= CAP_CNT)
   `SAT_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && req_ready, !req_ready)
   `SAT_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))

endmodule
